### src/d2i_pkg.sv
// Package: shared types and constants for the double to integer converter.
`timescale 1ns / 1ps

package d2i_pkg;

    localparam logic [10:0] EXP_ONE     = 11'h3FF;
    localparam logic [10:0] EXP_MAX_S32 = 11'd1053;
    localparam logic [10:0] EXP_MAX_MID = 11'd1085;
    localparam logic [10:0] EXP_MAX_U64 = 11'd1086;
    localparam logic [5:0]  SHIFT_BASE  = 6'h3E;

    localparam logic [63:0] UPPER_S32 = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] UPPER_S64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] LOWER_U32 = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] pre;
        logic [5:0]  shift;
        logic        neg;
        logic        ovf;
        logic        unf;
        logic        sgn_mode;
        logic        w32;
    } t_dec;

    typedef struct packed {
        logic [63:0] mag;
        logic        neg;
        logic        ovf;
        logic        unf;
        logic        sgn_mode;
        logic        w32;
    } t_mag;

    typedef struct packed {
        logic [63:0] result;
        logic        ovf;
        logic        unf;
    } t_res;

endpackage

### src/double_to_integer_convert.sv
// Top level: three-stage double to 64-bit integer converter.
`timescale 1ns / 1ps

// Converts one IEEE double word per cycle to a 64-bit integer, truncating toward
// zero, with overflow and underflow flags. Three register stages: decode/range
// check, a 64-bit barrel shift, and the negate/upper-bit fixup. A word accepted
// passes through the decode, shift and fixup registers in that order before it
// is valid on the output. Every stage has its own valid bit and holds its
// word under backpressure, so bubbles close up and a stall at the output
// neither drops nor repeats a word.

module double_to_integer_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_operand_bits,
    input  logic        i_signed_mode,
    input  logic        i_word32,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_integer_result,
    output logic        o_overflow_flag,
    output logic        o_underflow_flag
);
    import d2i_pkg::*;

    logic dec_valid;
    logic dec_ready;
    t_dec dec_data;
    logic mag_valid;
    logic mag_ready;
    t_mag mag_data;
    t_res res_data;

    d2i_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operand_bits (i_operand_bits),
        .i_signed_mode  (i_signed_mode),
        .i_word32       (i_word32),
        .o_valid        (dec_valid),
        .i_ready        (dec_ready),
        .o_data         (dec_data)
    );

    d2i_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_data  (dec_data),
        .o_valid (mag_valid),
        .i_ready (mag_ready),
        .o_data  (mag_data)
    );

    d2i_fixup u_fixup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mag_valid),
        .o_ready (mag_ready),
        .i_data  (mag_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (res_data)
    );

    assign o_integer_result = res_data.result;
    assign o_overflow_flag  = res_data.ovf;
    assign o_underflow_flag = res_data.unf;

endmodule

### src/d2i_decode.sv
// Stage 1: field unpack, shift amount and range checks.
`timescale 1ns / 1ps

module d2i_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [63:0]   i_operand_bits,
    input  logic          i_signed_mode,
    input  logic          i_word32,
    output logic          o_valid,
    input  logic          i_ready,
    output d2i_pkg::t_dec o_data
);
    import d2i_pkg::*;

    logic        r_valid;
    t_dec        r_data;
    t_dec        n_data;
    logic [10:0] expo;
    logic [10:0] emax;
    logic        neg;
    logic        ovf;

    always_comb begin
        expo = i_operand_bits[62:52];
        neg  = i_operand_bits[63];
        if (i_word32) begin
            emax = i_signed_mode ? EXP_MAX_S32 : EXP_MAX_MID;
        end else begin
            emax = (i_signed_mode || neg) ? EXP_MAX_MID : EXP_MAX_U64;
        end
        ovf              = expo > emax;
        n_data.pre       = {(expo != 11'd0), i_operand_bits[51:0], 11'd0};
        n_data.shift     = SHIFT_BASE - expo[5:0];
        n_data.neg       = neg;
        n_data.ovf       = ovf;
        n_data.unf       = !ovf && (expo < EXP_ONE);
        n_data.sgn_mode  = i_signed_mode;
        n_data.w32       = i_word32;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### src/d2i_shift.sv
// Stage 2: barrel shift of the aligned significand.
`timescale 1ns / 1ps

module d2i_shift (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  d2i_pkg::t_dec i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output d2i_pkg::t_mag o_data
);
    import d2i_pkg::*;

    logic r_valid;
    t_mag r_data;
    t_mag n_data;

    always_comb begin
        n_data.mag      = (i_data.ovf || i_data.unf) ? 64'd0 : (i_data.pre >> i_data.shift);
        n_data.neg      = i_data.neg;
        n_data.ovf      = i_data.ovf;
        n_data.unf      = i_data.unf;
        n_data.sgn_mode = i_data.sgn_mode;
        n_data.w32      = i_data.w32;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### src/d2i_fixup.sv
// Stage 3: sign apply and upper-bit forcing into the output register.
`timescale 1ns / 1ps

module d2i_fixup (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  d2i_pkg::t_mag i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output d2i_pkg::t_res o_data
);
    import d2i_pkg::*;

    logic        r_valid;
    t_res        r_data;
    t_res        n_data;
    logic        rsign;
    logic [63:0] res;

    always_comb begin
        rsign = (i_data.neg || i_data.ovf) && !i_data.unf;
        res   = i_data.neg ? (~i_data.mag + 64'd1) : i_data.mag;
        if (i_data.sgn_mode) begin
            if (rsign) begin
                res = res | (i_data.w32 ? UPPER_S32 : UPPER_S64);
            end
        end else begin
            if (i_data.w32) begin
                res = res & LOWER_U32;
            end else if (i_data.ovf) begin
                res = res | UPPER_S64;
            end
        end
        n_data.result = res;
        n_data.ovf    = i_data.ovf;
        n_data.unf    = i_data.unf;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### src/d2i_check.sv
// Checker: port-level assertions for the converter, bound to the top level.
`timescale 1ns / 1ps

module d2i_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_result,
    input logic        i_ovf,
    input logic        i_unf
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_ovf && i_unf))
        else $error("overflow and underflow both set");

    a_unf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_unf) |-> (i_result == 64'd0))
        else $error("underflow word has nonzero result");

    a_ovf_low_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_ovf) |-> (i_result[30:0] == 31'd0))
        else $error("overflow word has nonzero low bits");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_result) && $stable(i_ovf) && $stable(i_unf)))
        else $error("stalled output word changed");

endmodule

bind double_to_integer_convert d2i_check u_d2i_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_result    (o_integer_result),
    .i_ovf       (o_overflow_flag),
    .i_unf       (o_underflow_flag)
);
